[rtl/drp_pkg.sv]
// ---------------------------------------------------------------------------
// drp_pkg: shared types and constants for the decimal LSD radix sorter
// Record, transaction and count widths plus the divide-by-ten constants.
// ---------------------------------------------------------------------------
package drp_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 12;
    localparam int RADIX       = 10;
    localparam int DIG_W       = 4;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             final_res;
    } result_t;

    // quo holds key / weight for the current digit pass
    typedef struct packed {
        logic [KEY_W-1:0] quo;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

endpackage

[rtl/drp_div10.sv]
// ---------------------------------------------------------------------------
// drp_div10: shared divide-by-ten unit
// Splits a value into its quotient by ten and its low decimal digit.
// ---------------------------------------------------------------------------
module drp_div10
(
    input  logic [drp_pkg::KEY_W-1:0] value,
    output logic [drp_pkg::KEY_W-1:0] quo,
    output logic [drp_pkg::DIG_W-1:0] digit
);

    logic [drp_pkg::PROD_W-1:0] prod;
    logic [drp_pkg::KEY_W-1:0]  times10;

    // reciprocal multiply, exact for all 16-bit values
    assign prod    = drp_pkg::PROD_W'(value) * drp_pkg::PROD_W'(drp_pkg::RECIP_10);
    assign quo     = drp_pkg::KEY_W'(prod >> drp_pkg::RECIP_SHIFT);
    assign times10 = (quo << 3) + (quo << 1);
    assign digit   = drp_pkg::DIG_W'(value - times10);

endmodule

[rtl/decimal_lsd_radix_sorter.sv]
// ---------------------------------------------------------------------------
// decimal_lsd_radix_sorter: stable base-10 LSD radix sort of key/tag records
// Collects up to 64 records, sorts by key on the record marked last, then
// streams them out in ascending order.
// ---------------------------------------------------------------------------
// Loading takes a record on each idle cycle with start high; records past 64
// are dropped. The record marked last starts the sort. Each decimal digit pass
// (one per digit of the largest key, none if it is zero) over the n records is
// a count sweep, a prefix sum and a scatter sweep, all through one
// divide-by-ten unit and a single read port per record memory. Emission then
// puts one result per cycle on result, n in all, with final_res on the last
// one; the receiver cannot stall, so result_valid is a one-cycle strobe per
// result. busy stays high from the last record until the cycle that carries
// the final result.
module decimal_lsd_radix_sorter
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  drp_pkg::item_t   item,
    output logic             busy,
    output logic             result_valid,
    output drp_pkg::result_t result
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_COUNT   = 9'b000000010,
        S_CWAIT   = 9'b000000100,
        S_PREFIX  = 9'b000001000,
        S_SCATTER = 9'b000010000,
        S_SWAIT   = 9'b000100000,
        S_NEXT    = 9'b001000000,
        S_EMIT    = 9'b010000000,
        S_FLUSH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [drp_pkg::CNT_W-1:0] n_reg;
    logic [drp_pkg::KEY_W-1:0] largest_reg;
    logic [drp_pkg::KEY_W-1:0] lq_reg;
    logic                      bank_reg;
    logic [drp_pkg::IDX_W-1:0] idx_reg;
    logic [drp_pkg::CNT_W-1:0] cnt_reg [drp_pkg::RADIX];
    logic [drp_pkg::CNT_W-1:0] prefix  [drp_pkg::RADIX];
    logic                      pc_reg, ps_reg, pe_reg, pfin_reg;
    logic                      res_valid_reg;
    drp_pkg::result_t          res_reg;

    drp_pkg::rec_t mem_a [drp_pkg::MAX_ITEMS];
    drp_pkg::rec_t mem_b [drp_pkg::MAX_ITEMS];
    drp_pkg::rec_t rd_a, rd_b, rd_src, wdata;

    logic                      accept, full;
    logic [drp_pkg::KEY_W-1:0] largest_new;
    logic [drp_pkg::CNT_W-1:0] last_idx;
    logic                      issue_last;
    logic [drp_pkg::KEY_W-1:0] div_in, quo;
    logic [drp_pkg::DIG_W-1:0] dig;
    logic [drp_pkg::CNT_W-1:0] pos;
    logic                      we_a, we_b;
    logic [drp_pkg::IDX_W-1:0] waddr;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign accept      = start && (state_reg == S_IDLE);
    assign full        = (n_reg == drp_pkg::CNT_W'(drp_pkg::MAX_ITEMS));
    assign largest_new = (!full && item.key > largest_reg) ? item.key : largest_reg;
    assign last_idx    = n_reg - drp_pkg::CNT_W'(1);
    assign issue_last  = ({1'b0, idx_reg} == last_idx);

    assign rd_src = bank_reg ? rd_b : rd_a;
    assign div_in = (state_reg == S_NEXT) ? lq_reg : rd_src.quo;

    drp_div10 u_div10
    (
        .value (div_in),
        .quo   (quo),
        .digit (dig)
    );

    assign pos = cnt_reg[dig] - drp_pkg::CNT_W'(1);

    always_comb
    begin
        prefix[0] = cnt_reg[0];
        for (int d = 1; d < drp_pkg::RADIX; d++)
        begin
            prefix[d] = prefix[d-1] + cnt_reg[d];
        end
    end

    always_comb
    begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        waddr = pos[drp_pkg::IDX_W-1:0];
        wdata = '{quo: quo, key: rd_src.key, tag: rd_src.tag};
        if (accept && !full)
        begin
            we_a  = 1'b1;
            waddr = n_reg[drp_pkg::IDX_W-1:0];
            wdata = '{quo: item.key, key: item.key, tag: item.tag};
        end
        else if (ps_reg)
        begin
            we_a = bank_reg;
            we_b = !bank_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && item.last)
                begin
                    state_next = (largest_new == '0) ? S_EMIT : S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (issue_last)
                begin
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:   state_next = S_PREFIX;
            S_PREFIX:  state_next = S_SCATTER;
            S_SCATTER:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT:   state_next = S_NEXT;
            S_NEXT:    state_next = (quo == '0) ? S_EMIT : S_COUNT;
            S_EMIT:
            begin
                if (issue_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (pe_reg && pfin_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            largest_reg   <= '0;
            lq_reg        <= '0;
            bank_reg      <= 1'b0;
            idx_reg       <= '0;
            pc_reg        <= 1'b0;
            ps_reg        <= 1'b0;
            pe_reg        <= 1'b0;
            pfin_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int d = 0; d < drp_pkg::RADIX; d++)
            begin
                cnt_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= 1'b0;
            ps_reg        <= 1'b0;
            pe_reg        <= 1'b0;
            pfin_reg      <= 1'b0;
            res_valid_reg <= pe_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (!full)
                        begin
                            n_reg <= n_reg + drp_pkg::CNT_W'(1);
                        end
                        largest_reg <= largest_new;
                        if (item.last)
                        begin
                            bank_reg <= 1'b0;
                            lq_reg   <= largest_new;
                            idx_reg  <= '0;
                            for (int d = 0; d < drp_pkg::RADIX; d++)
                            begin
                                cnt_reg[d] <= '0;
                            end
                        end
                    end
                end
                S_COUNT:
                begin
                    pc_reg  <= 1'b1;
                    idx_reg <= idx_reg + drp_pkg::IDX_W'(1);
                end
                S_CWAIT:
                begin
                end
                S_PREFIX:
                begin
                    for (int d = 0; d < drp_pkg::RADIX; d++)
                    begin
                        cnt_reg[d] <= prefix[d];
                    end
                    idx_reg <= last_idx[drp_pkg::IDX_W-1:0];
                end
                S_SCATTER:
                begin
                    ps_reg  <= 1'b1;
                    idx_reg <= idx_reg - drp_pkg::IDX_W'(1);
                end
                S_SWAIT:
                begin
                end
                S_NEXT:
                begin
                    lq_reg   <= quo;
                    bank_reg <= !bank_reg;
                    idx_reg  <= '0;
                    for (int d = 0; d < drp_pkg::RADIX; d++)
                    begin
                        cnt_reg[d] <= '0;
                    end
                end
                S_EMIT:
                begin
                    pe_reg   <= 1'b1;
                    pfin_reg <= issue_last;
                    idx_reg  <= idx_reg + drp_pkg::IDX_W'(1);
                end
                S_FLUSH:
                begin
                    if (pe_reg && pfin_reg)
                    begin
                        n_reg       <= '0;
                        largest_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase

            // digit histogram on the count sweep, slot claim on the scatter sweep
            if (pc_reg)
            begin
                cnt_reg[dig] <= cnt_reg[dig] + drp_pkg::CNT_W'(1);
            end
            else if (ps_reg)
            begin
                cnt_reg[dig] <= pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[waddr] <= wdata;
        end
        if (we_b)
        begin
            mem_b[waddr] <= wdata;
        end
        rd_a <= mem_a[idx_reg];
        rd_b <= mem_b[idx_reg];
        if (pe_reg)
        begin
            res_reg <= '{sorted_key: rd_src.key, sorted_tag: rd_src.tag,
                         final_res: pfin_reg};
        end
    end

endmodule
